// ===== rtl/swr_pkg.sv =====
// shared types and constants for the stop-and-wait receiver
package swr_pkg;

  localparam int unsigned POS_W = 11;
  localparam logic [POS_W-1:0] HEADER_BYTES = 11'd12;
  localparam logic [POS_W-1:0] POS_MAX = 11'd2047;
  localparam logic [31:0] MAX_PAYLOAD = 32'd1024;

  // verdict codes
  localparam logic [1:0] VERDICT_GOOD = 2'd0;
  localparam logic [1:0] VERDICT_BAD_CHECKSUM = 2'd1;
  localparam logic [1:0] VERDICT_BAD_SEQUENCE = 2'd2;
  localparam logic [1:0] VERDICT_BAD_LENGTH = 2'd3;

  // header word indexes
  localparam logic [1:0] WORD_SEQUENCE = 2'd0;
  localparam logic [1:0] WORD_LENGTH = 2'd1;
  localparam logic [1:0] WORD_CHECKSUM = 2'd2;

  // one queued command: an optional payload word and an optional verdict word
  typedef struct packed {
    logic has_pay;
    logic has_vrd;
    logic [7:0] data_b;
    logic [1:0] verdict;
    logic ack_seq;
    logic [10:0] plen;
    logic done;
  } cmd_t;

  // front to queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  // queue to back
  typedef struct packed {
    logic head_valid;
    cmd_t head;
  } head_t;

endpackage

// ===== rtl/stop_and_wait_receiver_unit.sv =====
// Stop-and-wait datagram receiver: one byte per cycle in while the queue is not full, results through a queue.
// The command for an accepted byte is written into the queue as the byte is accepted.
// A byte ending a datagram inside the payload
// gives two result words, which the back end sends one after the other.
// The command queue (QUEUE_DEPTH entries) absorbs output stalls.
// Synchronous active-low reset clears all state, empties the queue, expects sequence 0.
module stop_and_wait_receiver_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic in_end_of_datagram,
  output logic out_valid,
  input  logic out_ready,
  output logic out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_verdict,
  output logic out_ack_sequence,
  output logic [10:0] out_payload_length,
  output logic out_transfer_done,
  output logic out_last_of_run
);

  swr_pkg::push_t push_s;
  swr_pkg::head_t head_s;
  logic full;
  logic pop;

  assign in_ready = !full;

  // byte intake and classification
  swr_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_end_of_datagram(in_end_of_datagram),
    .push_o(push_s)
  );

  // command queue
  swr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_i(push_s),
    .pop(pop),
    .full(full),
    .head_o(head_s)
  );

  // result word sequencing
  swr_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head_i(head_s),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_kind(out_result_kind),
    .out_payload_byte(out_payload_byte),
    .out_verdict(out_verdict),
    .out_ack_sequence(out_ack_sequence),
    .out_payload_length(out_payload_length),
    .out_transfer_done(out_transfer_done),
    .out_last_of_run(out_last_of_run)
  );

endmodule

// ===== rtl/swr_front.sv =====
// front end: header capture, running xor, classification of each byte
module swr_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic in_end_of_datagram,
  output swr_pkg::push_t push_o
);

  logic [swr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] chk_r, chk_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic exp_r, exp_nxt;
  logic fin_r, fin_nxt;

  logic accept;
  logic hdr;
  logic [1:0] widx;
  logic [31:0] lane;
  logic [swr_pkg::POS_W-1:0] pay_pos;
  logic len_ok;
  logic pay;
  logic len_ok_n;
  logic lok;
  logic [31:0] sx;
  logic [1:0] verdict;
  logic good;
  logic done;

  assign accept = in_valid && in_ready && !fin_r;

  // byte classification against the current header state
  always_comb begin
    hdr = pos_r < swr_pkg::HEADER_BYTES;
    widx = pos_r[3:2];
    lane = {24'd0, in_rx_byte} << {pos_r[1:0], 3'b000};
    pay_pos = pos_r - swr_pkg::HEADER_BYTES;
    len_ok = !len_r[31] && (len_r <= swr_pkg::MAX_PAYLOAD);
    pay = !hdr && len_ok && ({21'd0, pay_pos} < len_r);
  end

  // next header words, xor and position with this byte taken in
  always_comb begin
    seq_nxt = seq_r;
    len_nxt = len_r;
    chk_nxt = chk_r;
    if (hdr) begin
      unique case (widx)
        swr_pkg::WORD_SEQUENCE: seq_nxt = seq_r | lane;
        swr_pkg::WORD_LENGTH:   len_nxt = len_r | lane;
        swr_pkg::WORD_CHECKSUM: chk_nxt = chk_r | lane;
        default: ;
      endcase
    end
    xor_nxt = xor_r;
    if ((hdr && widx != swr_pkg::WORD_CHECKSUM) || pay) begin
      xor_nxt = xor_r ^ in_rx_byte;
    end
    pos_nxt = (pos_r == swr_pkg::POS_MAX) ? pos_r : pos_r + 11'd1;
  end

  // end-of-datagram verdict from the updated state
  always_comb begin
    len_ok_n = !len_nxt[31] && (len_nxt <= swr_pkg::MAX_PAYLOAD);
    lok = (pos_nxt >= swr_pkg::HEADER_BYTES) && len_ok_n &&
          ({21'd0, pos_nxt - swr_pkg::HEADER_BYTES} >= len_nxt);
    sx = {{24{xor_nxt[7]}}, xor_nxt};
    if (!lok) begin
      verdict = swr_pkg::VERDICT_BAD_LENGTH;
    end else if (chk_nxt != sx) begin
      verdict = swr_pkg::VERDICT_BAD_CHECKSUM;
    end else if (seq_nxt != {31'd0, exp_r}) begin
      verdict = swr_pkg::VERDICT_BAD_SEQUENCE;
    end else begin
      verdict = swr_pkg::VERDICT_GOOD;
    end
    good = verdict == swr_pkg::VERDICT_GOOD;
    done = good && (len_nxt == 32'd0);
  end

  // command toward the queue
  always_comb begin
    push_o.push = accept && (pay || in_end_of_datagram);
    push_o.cmd.has_pay = pay;
    push_o.cmd.has_vrd = in_end_of_datagram;
    push_o.cmd.data_b = in_rx_byte;
    push_o.cmd.verdict = verdict;
    push_o.cmd.ack_seq = good ? exp_r : !exp_r;
    push_o.cmd.plen = good ? len_nxt[10:0] : 11'd0;
    push_o.cmd.done = done;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      seq_r <= '0;
      len_r <= '0;
      chk_r <= '0;
      xor_r <= '0;
      exp_r <= 1'b0;
      fin_r <= 1'b0;
    end else if (accept) begin
      if (in_end_of_datagram) begin
        pos_r <= '0;
        seq_r <= '0;
        len_r <= '0;
        chk_r <= '0;
        xor_r <= '0;
        exp_r <= exp_nxt;
        fin_r <= fin_nxt;
      end else begin
        pos_r <= pos_nxt;
        seq_r <= seq_nxt;
        len_r <= len_nxt;
        chk_r <= chk_nxt;
        xor_r <= xor_nxt;
      end
    end
  end

  assign exp_nxt = good ? !exp_r : exp_r;
  assign fin_nxt = done;

  // once finished, the transfer stays finished until reset
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r) else $error("finished flag cleared");

  // a transfer-done command is always a good verdict
  a_done_good: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o.push && push_o.cmd.done) |->
      (push_o.cmd.has_vrd && push_o.cmd.verdict == swr_pkg::VERDICT_GOOD))
    else $error("done without good verdict");

endmodule

// ===== rtl/swr_queue.sv =====
// short command queue between front and back
module swr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  swr_pkg::push_t push_i,
  input  logic pop,
  output logic full,
  output swr_pkg::head_t head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  swr_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = count_r == CW'(DEPTH);
  assign do_push = push_i.push && !full;
  assign do_pop = pop && (count_r != '0);

  // head of queue
  assign head_o.head_valid = count_r != '0;
  assign head_o.head = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.cmd;
    end
  end

  // the front never offers a command the queue cannot hold
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push_i.push) else $error("push into full queue");

endmodule

// ===== rtl/swr_back.sv =====
// back end: turns each queued command into one or two result words
module swr_back (
  input  logic clk,
  input  logic rst_n,
  input  swr_pkg::head_t head_i,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_verdict,
  output logic out_ack_sequence,
  output logic [10:0] out_payload_length,
  output logic out_transfer_done,
  output logic out_last_of_run
);

  logic phase_r;
  logic show_pay;
  logic take;

  assign show_pay = head_i.head.has_pay && !phase_r;
  assign out_valid = head_i.head_valid;
  assign take = out_valid && out_ready;
  assign pop = take && !(show_pay && head_i.head.has_vrd);

  // result word fields: payload first, verdict second
  always_comb begin
    out_result_kind = !show_pay;
    out_payload_byte = show_pay ? head_i.head.data_b : 8'd0;
    out_verdict = show_pay ? swr_pkg::VERDICT_GOOD : head_i.head.verdict;
    out_ack_sequence = show_pay ? 1'b0 : head_i.head.ack_seq;
    out_payload_length = show_pay ? 11'd0 : head_i.head.plen;
    out_transfer_done = show_pay ? 1'b0 : head_i.head.done;
    out_last_of_run = show_pay ? !head_i.head.has_vrd : 1'b1;
  end

  // second-word phase of a two-word command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (take) begin
      phase_r <= show_pay && head_i.head.has_vrd;
    end
  end

  // the verdict phase only exists on a held two-word command
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_i.head_valid && head_i.head.has_pay && head_i.head.has_vrd))
    else $error("verdict phase without two-word head");

endmodule

// ===== tb/sv/swr_tb_pkg.sv =====
// result scoreboard and byte-level predictor for the stop-and-wait receiver testbench
package swr_tb_pkg;
  import swr_pkg::*;

  // one word on the result channel
  typedef struct packed {
    logic kind;
    logic [7:0] pay;
    logic [1:0] verdict;
    logic ack;
    logic [10:0] plen;
    logic done;
    logic last;
  } rx_word_t;

  class rx_scoreboard;
    // receiver state as the block should hold it
    logic [10:0] rx_pos = '0;
    logic [31:0] seq_w = '0;
    logic [31:0] len_w = '0;
    logic [31:0] csum_w = '0;
    logic [7:0] xor_acc = '0;
    logic want_seq = 1'b0;
    logic xfer_over = 1'b0;

    rx_word_t expected_q[$];
    int unsigned mismatches = 0;

    function bit len_in_range();
      return !len_w[31] && len_w <= MAX_PAYLOAD;
    endfunction

    // advance the receiver by one accepted byte and queue the words it must send
    function void note_byte(input logic [7:0] b, input logic eod);
      rx_word_t pay_w;
      rx_word_t vrd_w;
      bit has_pay;
      bit frame_ok;
      logic [31:0] sx;
      has_pay = 1'b0;
      if (xfer_over) return;

      // header bytes fill the three words, checksum bytes stay out of the xor
      if (rx_pos < HEADER_BYTES) begin
        case (rx_pos[3:2])
          WORD_SEQUENCE: seq_w |= 32'(b) << (32'(rx_pos[1:0]) * 8);
          WORD_LENGTH: len_w |= 32'(b) << (32'(rx_pos[1:0]) * 8);
          default: csum_w |= 32'(b) << (32'(rx_pos[1:0]) * 8);
        endcase
        if (rx_pos[3:2] != WORD_CHECKSUM) xor_acc ^= b;
      end else if (len_in_range() && 32'(rx_pos - HEADER_BYTES) < len_w) begin
        xor_acc ^= b;
        pay_w = '0;
        pay_w.pay = b;
        pay_w.last = !eod;
        has_pay = 1'b1;
      end
      rx_pos = (rx_pos < POS_MAX) ? rx_pos + 11'd1 : POS_MAX;
      if (has_pay) expected_q.push_back(pay_w);

      // verdict on the last byte: length, then checksum, then sequence
      if (eod) begin
        sx = {{24{xor_acc[7]}}, xor_acc};
        frame_ok = rx_pos >= HEADER_BYTES && len_in_range() &&
                   32'(rx_pos - HEADER_BYTES) >= len_w;
        vrd_w = '0;
        vrd_w.kind = 1'b1;
        vrd_w.last = 1'b1;
        if (!frame_ok) vrd_w.verdict = VERDICT_BAD_LENGTH;
        else if (csum_w != sx) vrd_w.verdict = VERDICT_BAD_CHECKSUM;
        else if (seq_w != 32'(want_seq)) vrd_w.verdict = VERDICT_BAD_SEQUENCE;
        else vrd_w.verdict = VERDICT_GOOD;
        if (vrd_w.verdict == VERDICT_GOOD) begin
          vrd_w.ack = want_seq;
          vrd_w.plen = len_w[10:0];
          if (len_w == 32'd0) begin
            vrd_w.done = 1'b1;
            xfer_over = 1'b1;
          end
          want_seq = ~want_seq;
        end else begin
          vrd_w.ack = ~want_seq;
        end
        expected_q.push_back(vrd_w);
        rx_pos = '0;
        seq_w = '0;
        len_w = '0;
        csum_w = '0;
        xor_acc = '0;
      end
    endfunction

    function void field_check(string what, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
      end
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(input rx_word_t got);
      rx_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      field_check("result_kind", 32'(want.kind), 32'(got.kind));
      field_check("payload_byte", 32'(want.pay), 32'(got.pay));
      field_check("verdict", 32'(want.verdict), 32'(got.verdict));
      field_check("ack_sequence", 32'(want.ack), 32'(got.ack));
      field_check("payload_length", 32'(want.plen), 32'(got.plen));
      field_check("transfer_done", 32'(want.done), 32'(got.done));
      field_check("last_of_run", 32'(want.last), 32'(got.last));
    endfunction
  endclass

endpackage

// ===== tb/sv/stop_and_wait_receiver_unit_tb.sv =====
// testbench top: drives datagram bytes with random gaps and checks every result word
module stop_and_wait_receiver_unit_tb;
  import swr_pkg::*;
  import swr_tb_pkg::*;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_SEQ,
    FR_SHORT,
    FR_BAD_LEN,
    FR_NOISE
  } frame_kind_e;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic in_end_of_datagram;
  logic out_valid;
  logic out_ready;
  logic out_result_kind;
  logic [7:0] out_payload_byte;
  logic [1:0] out_verdict;
  logic out_ack_sequence;
  logic [10:0] out_payload_length;
  logic out_transfer_done;
  logic out_last_of_run;

  rx_scoreboard sb;
  logic [7:0] frame_q[$];
  int unsigned counted_bytes;
  bit quiet_send;

  stop_and_wait_receiver_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_end_of_datagram(in_end_of_datagram),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_kind(out_result_kind),
    .out_payload_byte(out_payload_byte),
    .out_verdict(out_verdict),
    .out_ack_sequence(out_ack_sequence),
    .out_payload_length(out_payload_length),
    .out_transfer_done(out_transfer_done),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one byte, wait for the handshake, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int unsigned gap;
    int unsigned r;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_end_of_datagram <= eod;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, eod);
    if (!quiet_send) begin
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // send the staged datagram; noise may also end early datagrams inside it
  task automatic send_frame(input bit noisy);
    logic eod;
    foreach (frame_q[i]) begin
      eod = (i == frame_q.size() - 1) || (noisy && $urandom_range(0, 7) == 0);
      send_byte(frame_q[i], eod);
    end
  endtask

  // header with checksum bytes zeroed, then random body bytes
  function automatic void build_frame(input logic [31:0] seq, input logic [31:0] len_field,
                                      input int unsigned body_n);
    frame_q.delete();
    for (int i = 0; i < 4; i++) frame_q.push_back(seq[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame_q.push_back(len_field[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame_q.push_back(8'h00);
    repeat (body_n) frame_q.push_back(8'($urandom));
  endfunction

  // fill in the checksum word, correct or deliberately wrong
  function automatic void seal_frame(input bit sum_good);
    logic [7:0] acc;
    logic [31:0] lf;
    logic [31:0] csum;
    int unsigned body_n;
    int unsigned covered;
    lf = {frame_q[7], frame_q[6], frame_q[5], frame_q[4]};
    body_n = frame_q.size() - 12;
    acc = '0;
    for (int i = 0; i < 8; i++) acc ^= frame_q[i];
    covered = 0;
    if (!lf[31] && lf <= MAX_PAYLOAD) covered = (lf < body_n) ? lf : body_n;
    for (int i = 0; i < covered; i++) acc ^= frame_q[12 + i];
    csum = {{24{acc[7]}}, acc};
    if (!sum_good) begin
      // zero extension of a negative xor must be rejected too
      if (acc[7] && $urandom_range(0, 1) == 1) csum = {24'h0, acc};
      else csum ^= 32'($urandom) | (32'h1 << $urandom_range(0, 31));
    end
    for (int i = 0; i < 4; i++) frame_q[8 + i] = csum[8*i +: 8];
  endfunction

  // one random datagram, mostly well formed
  task automatic random_frame();
    frame_kind_e kind;
    int unsigned r;
    int unsigned len;
    int unsigned len0;
    int unsigned extra;
    logic [31:0] want;
    logic [31:0] seq;
    logic [31:0] lf;
    want = {31'b0, sb.want_seq};
    r = $urandom_range(0, 99);
    kind = (r < 55) ? FR_GOOD : (r < 65) ? FR_BAD_SUM : (r < 75) ? FR_BAD_SEQ :
           (r < 83) ? FR_SHORT : (r < 93) ? FR_BAD_LEN : FR_NOISE;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
    len0 = ($urandom_range(0, 3) == 0) ? 0 : len;
    case (kind)
      FR_GOOD: begin
        build_frame(want, len, len);
        seal_frame(1'b1);
      end
      FR_BAD_SUM: begin
        build_frame(want, len0, len0);
        seal_frame(1'b0);
      end
      FR_BAD_SEQ: begin
        seq = ($urandom_range(0, 1) == 1) ? {31'b0, ~sb.want_seq} :
              (32'($urandom) | (32'h2 << $urandom_range(0, 30)));
        build_frame(seq, len0, len0);
        seal_frame(1'b1);
      end
      FR_SHORT: begin
        build_frame(want, len, len);
        seal_frame(1'b1);
        r = $urandom_range(1, 11 + len);
        while (frame_q.size() > r) void'(frame_q.pop_back());
      end
      FR_BAD_LEN: begin
        lf = ($urandom_range(0, 1) == 1) ? (32'($urandom) | 32'h8000_0000) :
             32'($urandom_range(1025, 32'h7FFF_FFFF));
        build_frame(want, lf, $urandom_range(0, 8));
        seal_frame(1'b1);
      end
      default: begin
        frame_q.delete();
        repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
      end
    endcase
    extra = 0;
    if (kind != FR_SHORT && kind != FR_NOISE && $urandom_range(0, 9) == 0) begin
      extra = $urandom_range(1, 6);
      repeat (extra) frame_q.push_back(8'($urandom));
    end
    counted_bytes += frame_q.size() - extra;
    quiet_send = ($urandom_range(0, 3) == 0);
    send_frame(kind == FR_NOISE);
  endtask

  // stimulus and end of run
  initial begin
    sb = new;
    quiet_send = 1'b0;
    counted_bytes = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    in_end_of_datagram <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // good one-byte payload whose xor is negative
    build_frame(32'd0, 32'd1, 1);
    frame_q[12] = 8'hFF;
    seal_frame(1'b1);
    send_frame(1'b0);
    // datagram ending inside the header
    frame_q.delete();
    frame_q.push_back(8'h00);
    send_frame(1'b0);
    // good two-byte payload, positive xor, one trailing byte ignored
    build_frame(32'd1, 32'd2, 3);
    frame_q[12] = 8'h00;
    frame_q[13] = 8'h7F;
    seal_frame(1'b1);
    send_frame(1'b0);

    while (counted_bytes < 950) random_frame();

    // length at the limit passes payload but ends short, one past it passes none
    quiet_send = 1'b0;
    build_frame({31'b0, sb.want_seq}, MAX_PAYLOAD, 20);
    seal_frame(1'b1);
    send_frame(1'b0);
    build_frame({31'b0, sb.want_seq}, MAX_PAYLOAD + 32'd1, 4);
    seal_frame(1'b1);
    send_frame(1'b0);
    // good empty datagram ends the transfer, later bytes are ignored
    build_frame({31'b0, sb.want_seq}, 32'd0, 0);
    seal_frame(1'b1);
    send_frame(1'b0);
    repeat (8) send_byte(8'($urandom), 1'($urandom));
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: check accepted words, stall at random, one long hold-off
  initial begin
    rx_word_t got;
    int unsigned stall_left;
    int unsigned phase_left;
    int unsigned seen;
    int unsigned r;
    bit calm;
    bit held;
    out_ready <= 1'b0;
    stall_left = 0;
    phase_left = 0;
    seen = 0;
    calm = 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
        got = '{out_result_kind, out_payload_byte, out_verdict, out_ack_sequence,
                out_payload_length, out_transfer_done, out_last_of_run};
        sb.check_word(got);
        seen++;
      end
      // alternate stretches of steady acceptance and random stalls
      if (phase_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      // hold off long enough for the queue to fill and stall the input
      if (!held && seen >= 150) begin
        held = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r >= 95) stall_left = $urandom_range(10, 30);
          else if (r >= 65) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== stop_and_wait_receiver_unit.f =====
rtl/swr_pkg.sv
rtl/swr_front.sv
rtl/swr_queue.sv
rtl/swr_back.sv
rtl/stop_and_wait_receiver_unit.sv
tb/sv/swr_tb_pkg.sv
tb/sv/stop_and_wait_receiver_unit_tb.sv
